>>> rtl/upb_pkg.sv
// Shared types and constants for the ultrasonic ranger and proximity beeper.
`timescale 1ns / 1ps

package upb_pkg;

    localparam int COUNT_W    = 16;
    localparam int DIST_W     = 14;
    localparam int STATUS_W   = 3;
    localparam int MS_W       = 16;
    localparam int ELAPSED_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT_ECHO,
        PH_WAIT_FALL,
        PH_DONE
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_NO_POLL   = 3'd0,
        ST_BUSY      = 3'd1,
        ST_OK        = 3'd2,
        ST_RANGE_ERR = 3'd3,
        ST_NO_ECHO   = 3'd4,
        ST_TOO_FAR   = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIG_TICKS = 3'd0,
        REG_TIMEOUT_MS = 3'd1,
        REG_MIN_VALID  = 3'd2,
        REG_MAX_VALID  = 3'd3,
        REG_RADAR_FAR  = 3'd4,
        REG_BEEP_MS    = 3'd5
    } t_cfg_reg;

    // Register reset values.
    localparam logic [7:0]         RST_TRIG_TICKS = 8'd40;
    localparam logic [9:0]         RST_TIMEOUT_MS = 10'd60;
    localparam logic [COUNT_W-1:0] RST_MIN_VALID  = 16'd232;
    localparam logic [COUNT_W-1:0] RST_MAX_VALID  = 16'd46400;
    localparam logic [COUNT_W-1:0] RST_RADAR_FAR  = 16'd2320;
    localparam logic [MS_W-1:0]    RST_BEEP_MS    = 16'd100;

    // Echo count of the nearest beeping distance (2 cm).
    localparam logic [COUNT_W-1:0]   NEAR_COUNT    = 16'd232;
    localparam logic [ELAPSED_W-1:0] MS_SAT        = 11'd2047;
    // Beep interval runs from BEEP_BASE_MS up by BEEP_SPAN_MS across the radar range.
    localparam logic [MS_W-1:0]      BEEP_BASE_MS  = 16'd100;
    localparam logic [11:0]          BEEP_SPAN_MS  = 12'd2900;

    // count*4/29 is taken as count * ceil(2^23/29) / 2^21, exact for 16-bit counts.
    localparam logic [18:0] DIST_RECIP = 19'd289263;
    localparam int          DIST_SHIFT = 21;

endpackage

>>> rtl/upb_if.sv
// Handshake channel interfaces: tick input, result output and register writes.
`timescale 1ns / 1ps

interface upb_in_if;
    logic valid;
    logic ready;
    logic echo;
    logic ms_strobe;
    logic poll;

    modport source (output valid, output echo, output ms_strobe, output poll, input ready);
    modport sink   (input valid, input echo, input ms_strobe, input poll, output ready);
endinterface

interface upb_out_if
    import upb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                trig;
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance_q4;
    logic [COUNT_W-1:0]  echo_count;
    logic                horn_on;

    modport source (output valid, output trig, output status, output distance_q4,
                    output echo_count, output horn_on, input ready);
    modport sink   (input valid, input trig, input status, input distance_q4,
                    input echo_count, input horn_on, output ready);
endinterface

interface upb_cfg_if
    import upb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/upb_range_calc.sv
// Distance conversion and beep interval check for one echo count.
`timescale 1ns / 1ps

module upb_range_calc
    import upb_pkg::*;
(
    input  logic [COUNT_W-1:0] i_count,
    input  logic [MS_W-1:0]    i_elapsed_ms,
    input  logic [COUNT_W-1:0] i_radar_far,
    output logic [DIST_W-1:0]  o_distance_q4,
    output logic               o_beep_due
);

    logic [COUNT_W+18:0] dist_prod;
    logic                far_above;
    logic [COUNT_W-1:0]  span;
    logic [COUNT_W-1:0]  cnt_off;
    logic [MS_W-1:0]     e_off;
    logic [27:0]         x_num;
    logic [31:0]         limit;

    assign dist_prod     = (COUNT_W + 19)'(i_count) * (COUNT_W + 19)'(DIST_RECIP);
    assign o_distance_q4 = dist_prod[DIST_SHIFT +: DIST_W];

    // The interval 100 + floor(2900*(c-232)/span) has passed when
    // 2900*(c-232) < (elapsed-99)*span, which avoids a divider.
    assign far_above = i_radar_far > NEAR_COUNT;
    assign span      = i_radar_far - NEAR_COUNT;
    assign cnt_off   = i_count - NEAR_COUNT;
    assign e_off     = i_elapsed_ms - (BEEP_BASE_MS - 16'd1);
    assign x_num     = 28'(cnt_off) * 28'(BEEP_SPAN_MS);
    assign limit     = 32'(e_off) * 32'(span);

    assign o_beep_due = (i_elapsed_ms >= BEEP_BASE_MS) && (!far_above || ({4'd0, x_num} < limit));

endmodule

>>> rtl/ultrasonic_ranger_proximity_beeper.sv
// Top level of the ultrasonic time-of-flight ranger with proximity beeper.
//
//   channel  direction  payload                                          transfer when
//   i_in     in         echo, ms_strobe, poll (one 0.5 us tick)          valid & ready
//   o_out    out        trig, status, distance_q4, echo_count, horn_on   valid & ready
//   i_cfg    in         index (3 bits), data (16 bits)                   valid & ready
//
// One tick is accepted per cycle while results are taken; its result passes from the input register
// through the state update into the result register, from which it is presented.
// The rate is set by the combinational state update between those two registers.
// Reset (synchronous, active low) restores the register defaults and idles the ranger.
// A stalled result holds; one further tick waits in the input register, then
// i_in.ready falls. Register writes are always taken.
`timescale 1ns / 1ps

module ultrasonic_ranger_proximity_beeper
    import upb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    upb_in_if.sink    i_in,
    upb_out_if.source o_out,
    upb_cfg_if.sink   i_cfg
);

    // Configuration registers.
    logic [7:0]         r_trig_ticks;
    logic [9:0]         r_timeout_ms;
    logic [COUNT_W-1:0] r_min_valid;
    logic [COUNT_W-1:0] r_max_valid;
    logic [COUNT_W-1:0] r_radar_far;
    logic [MS_W-1:0]    r_beep_ms;

    // Input register.
    logic r_in_valid;
    logic r_in_echo;
    logic r_in_strobe;
    logic r_in_poll;

    // Ranger state.
    t_phase               r_phase, n_phase;
    logic [7:0]           r_trig_left, n_trig_left;
    logic [COUNT_W-1:0]   r_timer, n_timer;
    logic                 r_echo_prev;
    logic [COUNT_W-1:0]   r_captured, n_captured;
    logic [ELAPSED_W-1:0] r_ms_since, n_ms_since;
    logic [MS_W-1:0]      r_now_ms, n_now_ms;
    logic [MS_W-1:0]      r_last_beep, n_last_beep;
    logic [MS_W-1:0]      r_beep_start, n_beep_start;
    logic                 r_beeping, n_beeping;

    // Result register.
    logic                r_out_valid;
    logic                r_out_trig;
    logic [STATUS_W-1:0] r_out_status;
    logic [DIST_W-1:0]   r_out_dist;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_horn;

    logic               in_take;
    logic               advance;
    t_phase             ph_tick;
    logic [COUNT_W-1:0] cw_tick;
    t_status            status;
    logic [COUNT_W-1:0] cnt;
    logic               ok;
    logic [DIST_W-1:0]  range_q4;
    logic               beep_due;
    logic               beep_mid;
    logic               in_window;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_ticks <= RST_TRIG_TICKS;
            r_timeout_ms <= RST_TIMEOUT_MS;
            r_min_valid  <= RST_MIN_VALID;
            r_max_valid  <= RST_MAX_VALID;
            r_radar_far  <= RST_RADAR_FAR;
            r_beep_ms    <= RST_BEEP_MS;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_TRIG_TICKS: r_trig_ticks <= i_cfg.data[7:0];
                REG_TIMEOUT_MS: r_timeout_ms <= i_cfg.data[9:0];
                REG_MIN_VALID:  r_min_valid  <= i_cfg.data;
                REG_MAX_VALID:  r_max_valid  <= i_cfg.data;
                REG_RADAR_FAR:  r_radar_far  <= i_cfg.data;
                REG_BEEP_MS:    r_beep_ms    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_echo   <= i_in.echo;
            r_in_strobe <= i_in.ms_strobe;
            r_in_poll   <= i_in.poll;
        end
    end

    // State register of the ranger.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_trig_left  <= '0;
            r_timer      <= '0;
            r_echo_prev  <= 1'b0;
            r_captured   <= '0;
            r_ms_since   <= '0;
            r_now_ms     <= '0;
            r_last_beep  <= '0;
            r_beep_start <= '0;
            r_beeping    <= 1'b0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_trig_left  <= n_trig_left;
            r_timer      <= n_timer;
            r_echo_prev  <= r_in_echo;
            r_captured   <= n_captured;
            r_ms_since   <= n_ms_since;
            r_now_ms     <= n_now_ms;
            r_last_beep  <= n_last_beep;
            r_beep_start <= n_beep_start;
            r_beeping    <= n_beeping;
        end
    end

    // Millisecond strobe, trigger countdown, echo edges, then the poll.
    always_comb begin
        n_now_ms    = r_now_ms;
        n_ms_since  = r_ms_since;
        n_trig_left = r_trig_left;
        n_timer     = r_timer;
        ph_tick     = r_phase;
        cw_tick     = r_captured;
        status      = ST_NO_POLL;
        cnt         = '0;
        ok          = 1'b0;

        if (r_in_strobe) begin
            n_now_ms = r_now_ms + 16'd1;
            if ((r_phase == PH_WAIT_ECHO || r_phase == PH_WAIT_FALL) && r_ms_since != MS_SAT) begin
                n_ms_since = r_ms_since + 11'd1;
            end
        end

        if (r_phase == PH_TRIG) begin
            n_trig_left = r_trig_left - 8'd1;
            if (n_trig_left == 8'd0) begin
                ph_tick    = PH_WAIT_ECHO;
                n_ms_since = '0;
            end
        end

        // An echo already high when waiting begins shows no rising edge and is ignored.
        if (ph_tick == PH_WAIT_ECHO) begin
            if (r_in_echo && !r_echo_prev) begin
                n_timer = '0;
                ph_tick = PH_WAIT_FALL;
            end
        end else if (ph_tick == PH_WAIT_FALL) begin
            n_timer = r_timer + 16'd1;
            if (!r_in_echo && r_echo_prev) begin
                cw_tick = n_timer;
                ph_tick = PH_DONE;
            end
        end

        n_phase    = ph_tick;
        n_captured = cw_tick;

        if (r_in_poll) begin
            case (ph_tick)
                PH_DONE: begin
                    cnt        = cw_tick;
                    n_captured = '0;
                    n_phase    = PH_IDLE;
                    if (cw_tick < r_min_valid || cw_tick > r_max_valid) begin
                        status = ST_RANGE_ERR;
                    end else begin
                        status = ST_OK;
                        ok     = 1'b1;
                    end
                end
                PH_IDLE: begin
                    n_phase     = PH_TRIG;
                    n_trig_left = (r_trig_ticks == 8'd0) ? 8'd1 : r_trig_ticks;
                    status      = ST_BUSY;
                end
                PH_WAIT_ECHO, PH_WAIT_FALL: begin
                    if (n_ms_since > {1'b0, r_timeout_ms}) begin
                        status     = (ph_tick == PH_WAIT_FALL) ? ST_TOO_FAR : ST_NO_ECHO;
                        n_phase    = PH_IDLE;
                        n_captured = '0;
                    end else begin
                        status = ST_BUSY;
                    end
                end
                default: status = ST_BUSY;
            endcase
        end
    end

    upb_range_calc u_range_calc (
        .i_count       (cnt),
        .i_elapsed_ms  (n_now_ms - r_last_beep),
        .i_radar_far   (r_radar_far),
        .o_distance_q4 (range_q4),
        .o_beep_due    (beep_due)
    );

    // Radar step: start a beep on a near ok result, stop it when out of range or timed out.
    always_comb begin
        n_last_beep  = r_last_beep;
        n_beep_start = r_beep_start;
        beep_mid     = r_beeping;
        n_beeping    = r_beeping;
        in_window    = (cnt >= NEAR_COUNT) && (cnt <= r_radar_far);

        if (r_in_poll) begin
            if (ok) begin
                if (in_window) begin
                    if (!r_beeping && beep_due) begin
                        n_last_beep  = n_now_ms;
                        n_beep_start = n_now_ms;
                        beep_mid     = 1'b1;
                    end
                end else begin
                    beep_mid = 1'b0;
                end
            end
            n_beeping = beep_mid;
            if (beep_mid && ((n_now_ms - n_beep_start) >= r_beep_ms)) begin
                n_beeping = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_trig   <= (n_phase == PH_TRIG);
            r_out_status <= status;
            r_out_dist   <= range_q4;
            r_out_count  <= cnt;
            r_out_horn   <= n_beeping;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.trig        = r_out_trig;
    assign o_out.status      = r_out_status;
    assign o_out.distance_q4 = r_out_dist;
    assign o_out.echo_count  = r_out_count;
    assign o_out.horn_on     = r_out_horn;

endmodule

>>> verif/ultrasonic_ranger_proximity_beeper_tb.sv
// Self-checking testbench for the ultrasonic ranger with proximity beeper.
`timescale 1ns / 1ps

module ultrasonic_ranger_proximity_beeper_tb;
    import upb_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int BLOCK_TICKS    = 50;
    localparam int LONG_PCT       = 20;

    // Opening ticks as {echo, ms_strobe, poll}, oldest first. They walk through
    // an idle tick, an echo outside any measurement, an echo already high when
    // waiting begins, a too-far and a no-echo timeout, an ok result, and a range
    // error collected on the very tick the echo falls.
    localparam logic [68:0] OPENING_TICKS = {
        3'b000, 3'b110, 3'b101, 3'b101, 3'b010, 3'b010, 3'b100, 3'b101,
        3'b001, 3'b010, 3'b010, 3'b011, 3'b001, 3'b100, 3'b000, 3'b110,
        3'b001, 3'b001, 3'b100, 3'b100, 3'b100, 3'b011, 3'b111
    };

    typedef struct packed {
        logic echo;
        logic ms_strobe;
        logic poll;
    } t_tick;

    typedef struct packed {
        logic               trig;
        t_status            status;
        logic [DIST_W-1:0]  distance_q4;
        logic [COUNT_W-1:0] echo_count;
        logic               horn_on;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n;

    upb_in_if  tick_if();
    upb_out_if reading_if();
    upb_cfg_if cfg_if();

    ultrasonic_ranger_proximity_beeper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (reading_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register settings as the ranger should currently hold them.
    logic [7:0]         set_trig_ticks = RST_TRIG_TICKS;
    logic [9:0]         set_timeout_ms = RST_TIMEOUT_MS;
    logic [COUNT_W-1:0] set_min_valid  = RST_MIN_VALID;
    logic [COUNT_W-1:0] set_max_valid  = RST_MAX_VALID;
    logic [COUNT_W-1:0] set_radar_far  = RST_RADAR_FAR;
    logic [MS_W-1:0]    set_beep_ms    = RST_BEEP_MS;

    // Ranger state as it should evolve tick by tick.
    t_phase             rg_phase         = PH_IDLE;
    logic [7:0]         rg_trig_left     = '0;
    logic [COUNT_W-1:0] rg_echo_timer    = '0;
    logic               rg_echo_prev     = 1'b0;
    logic [COUNT_W-1:0] rg_captured      = '0;
    logic [ELAPSED_W-1:0] rg_ms_since    = '0;
    logic [MS_W-1:0]    rg_now_ms        = '0;
    logic [MS_W-1:0]    rg_last_beep_ms  = '0;
    logic [MS_W-1:0]    rg_beep_start_ms = '0;
    logic               rg_beeping       = 1'b0;

    t_tick    tick_q[$];
    t_reading due_readings[$];
    t_tick    next_tick;
    t_reading seen;

    int unsigned queued_ticks = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned gen_trig = RST_TRIG_TICKS;
    int unsigned gen_timeout = RST_TIMEOUT_MS;
    int unsigned mismatches = 0;
    int unsigned readings_seen = 0;
    int unsigned quiet_cycles = 0;
    logic        tick_taken;

    function automatic int unsigned beep_gap_ms(logic [COUNT_W-1:0] cnt);
        if (set_radar_far <= NEAR_COUNT) return BEEP_BASE_MS;
        return BEEP_BASE_MS + (BEEP_SPAN_MS * (32'(cnt) - NEAR_COUNT))
               / (32'(set_radar_far) - NEAR_COUNT);
    endfunction

    // Advances the ranger by one tick and returns the reading it should report.
    function automatic t_reading range_tick(t_tick tk);
        t_reading           rd;
        logic [COUNT_W-1:0] cnt;
        logic               good;
        rd = '0;
        rd.status = ST_NO_POLL;
        cnt = '0;
        good = 1'b0;

        if (tk.ms_strobe) begin
            rg_now_ms = rg_now_ms + 1'b1;
            if ((rg_phase == PH_WAIT_ECHO || rg_phase == PH_WAIT_FALL) && rg_ms_since < MS_SAT)
                rg_ms_since = rg_ms_since + 1'b1;
        end

        if (rg_phase == PH_TRIG) begin
            rg_trig_left = rg_trig_left - 1'b1;
            if (rg_trig_left == 0) begin
                rg_phase = PH_WAIT_ECHO;
                rg_ms_since = '0;
            end
        end

        case (rg_phase)
            PH_WAIT_ECHO: begin
                if (tk.echo && !rg_echo_prev) begin
                    rg_echo_timer = '0;
                    rg_phase = PH_WAIT_FALL;
                end
            end
            PH_WAIT_FALL: begin
                rg_echo_timer = rg_echo_timer + 1'b1;
                if (!tk.echo && rg_echo_prev) begin
                    rg_captured = rg_echo_timer;
                    rg_phase = PH_DONE;
                end
            end
            default: ;
        endcase
        rg_echo_prev = tk.echo;

        if (tk.poll) begin
            if (rg_phase == PH_DONE) begin
                cnt = rg_captured;
                rg_captured = '0;
                rg_phase = PH_IDLE;
                rd.distance_q4 = DIST_W'((32'(cnt) * 4) / 29);
                rd.echo_count = cnt;
                if (cnt < set_min_valid || cnt > set_max_valid) begin
                    rd.status = ST_RANGE_ERR;
                end else begin
                    rd.status = ST_OK;
                    good = 1'b1;
                end
            end else if (rg_phase == PH_IDLE) begin
                rg_phase = PH_TRIG;
                rg_trig_left = (set_trig_ticks == 0) ? 8'd1 : set_trig_ticks;
                rd.status = ST_BUSY;
            end else if ((rg_phase == PH_WAIT_ECHO || rg_phase == PH_WAIT_FALL)
                         && rg_ms_since > set_timeout_ms) begin
                rd.status = (rg_phase == PH_WAIT_FALL) ? ST_TOO_FAR : ST_NO_ECHO;
                rg_phase = PH_IDLE;
                rg_captured = '0;
            end else begin
                rd.status = ST_BUSY;
            end

            // Only an ok result steers the beeper by range; an ok result outside the radar range silences it.
            if (good) begin
                if (cnt >= NEAR_COUNT && cnt <= set_radar_far) begin
                    if (!rg_beeping
                        && 16'(rg_now_ms - rg_last_beep_ms) >= beep_gap_ms(cnt)) begin
                        rg_last_beep_ms = rg_now_ms;
                        rg_beep_start_ms = rg_now_ms;
                        rg_beeping = 1'b1;
                    end
                end else begin
                    rg_beeping = 1'b0;
                end
            end
            if (rg_beeping && 16'(rg_now_ms - rg_beep_start_ms) >= set_beep_ms)
                rg_beeping = 1'b0;
        end

        rd.trig = (rg_phase == PH_TRIG);
        rd.horn_on = rg_beeping;
        return rd;
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
        case (t_cfg_reg'(idx))
            REG_TRIG_TICKS: set_trig_ticks = value[7:0];
            REG_TIMEOUT_MS: set_timeout_ms = value[9:0];
            REG_MIN_VALID:  set_min_valid  = value;
            REG_MAX_VALID:  set_max_valid  = value;
            REG_RADAR_FAR:  set_radar_far  = value;
            REG_BEEP_MS:    set_beep_ms    = value;
            default: ;
        endcase
    endfunction

    function automatic logic coin(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic void add_tick(logic e, logic s, logic p);
        tick_q.push_back('{echo: e, ms_strobe: s, poll: p});
        queued_ticks++;
    endfunction

    // One measurement: start, trigger, then an echo of some width or a timeout,
    // and finally a poll to collect the outcome.
    task automatic queue_ranging();
        int unsigned v;
        int unsigned len;
        int unsigned sp;
        int unsigned pp;
        v = $urandom_range(99);
        sp = 20;
        pp = 3;
        add_tick(1'b0, coin(sp), 1'b1);
        repeat ((gen_trig == 0) ? 1 : gen_trig) add_tick(1'b0, coin(sp), coin(4));
        repeat ($urandom_range(3)) add_tick(1'b0, coin(sp), 1'b0);
        if (v < 8 && gen_timeout < 100) begin
            repeat (gen_timeout + 1 + $urandom_range(2)) add_tick(1'b0, 1'b1, 1'b0);
            add_tick(1'b0, 1'b0, 1'b1);
        end else if (v < 16 && gen_timeout < 100) begin
            add_tick(1'b1, 1'b0, 1'b0);
            repeat (gen_timeout + 1 + $urandom_range(2)) add_tick(1'b1, 1'b1, 1'b0);
            add_tick(1'b1, 1'b0, 1'b1);
            add_tick(1'b0, 1'b0, 1'b0);
        end else begin
            if (coin(LONG_PCT)) begin
                // Widths around the near limit reach the beeper; frequent strobes let
                // enough milliseconds pass between beeps.
                len = $urandom_range(300, 226);
                sp = 50;
                pp = 0;
            end else begin
                len = $urandom_range(24, 1);
            end
            repeat (len) add_tick(1'b1, coin(sp), coin(pp));
            if (coin(25)) begin
                add_tick(1'b0, coin(sp), 1'b1);
            end else begin
                add_tick(1'b0, coin(sp), 1'b0);
                repeat ($urandom_range(2)) add_tick(coin(50), coin(sp), 1'b0);
                add_tick(coin(50), coin(sp), 1'b1);
            end
        end
    endtask

    task automatic cfg_write(t_cfg_reg idx, int unsigned value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        if (idx == REG_TRIG_TICKS) gen_trig = value;
        if (idx == REG_TIMEOUT_MS) gen_timeout = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_block(int unsigned trig, int unsigned timeout, int unsigned lo,
                             int unsigned hi, int unsigned far, int unsigned beep);
        cfg_write(REG_TRIG_TICKS, trig);
        cfg_write(REG_TIMEOUT_MS, timeout);
        cfg_write(REG_MIN_VALID, lo);
        cfg_write(REG_MAX_VALID, hi);
        cfg_write(REG_RADAR_FAR, far);
        cfg_write(REG_BEEP_MS, beep);
    endtask

    // Waits until every tick has been taken and every reading has come back.
    task automatic settle();
        while (tick_q.size() != 0 || tick_if.valid || due_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Tick driver; it also drives the reading ready.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!tick_if.valid || tick_taken) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_tick = tick_q.pop_front();
                    tick_if.valid     <= 1'b1;
                    tick_if.echo      <= next_tick.echo;
                    tick_if.ms_strobe <= next_tick.ms_strobe;
                    tick_if.poll      <= next_tick.poll;
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
            reading_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor, reading check and watchdog.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_taken <= 1'b0;
        end else begin
            tick_taken <= tick_if.valid && tick_if.ready;
            if (cfg_if.valid && cfg_if.ready)
                apply_setting(cfg_if.index, cfg_if.data);

            // The reading leaving now belongs to an older tick, so check before queueing.
            if (reading_if.valid && reading_if.ready) begin
                readings_seen++;
                seen.trig        = reading_if.trig;
                seen.status      = t_status'(reading_if.status);
                seen.distance_q4 = reading_if.distance_q4;
                seen.echo_count  = reading_if.echo_count;
                seen.horn_on     = reading_if.horn_on;
                if (due_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reading %0d arrived with none outstanding", readings_seen);
                end else if (seen !== due_readings[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"reading %0d: expected trig=%0d status=%0d dist=%0d ",
                                  "count=%0d horn=%0d, got trig=%0d status=%0d dist=%0d ",
                                  "count=%0d horn=%0d"}, readings_seen,
                                 due_readings[0].trig, due_readings[0].status,
                                 due_readings[0].distance_q4, due_readings[0].echo_count,
                                 due_readings[0].horn_on, seen.trig, seen.status,
                                 seen.distance_q4, seen.echo_count, seen.horn_on);
                    void'(due_readings.pop_front());
                end else begin
                    void'(due_readings.pop_front());
                end
            end

            if (tick_if.valid && tick_if.ready)
                due_readings.push_back(range_tick('{echo: tick_if.echo,
                                                    ms_strobe: tick_if.ms_strobe,
                                                    poll: tick_if.poll}));

            if ((tick_if.valid && tick_if.ready) || (reading_if.valid && reading_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("ultrasonic_ranger_proximity_beeper test failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int unsigned blk;
        int unsigned start;
        i_rst_n = 1'b0;
        tick_if.valid = 1'b0;
        tick_if.echo = 1'b0;
        tick_if.ms_strobe = 1'b0;
        tick_if.poll = 1'b0;
        reading_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 8;
        recv_idle_pct = 53;
        // A zero trigger length must behave as one tick; a one-millisecond timeout
        // and a narrow valid window make every outcome reachable in a few ticks.
        cfg_write(REG_TRIG_TICKS, 0);
        cfg_write(REG_TIMEOUT_MS, 1);
        cfg_write(REG_MIN_VALID, 1);
        cfg_write(REG_MAX_VALID, 2);
        for (int i = 22; i >= 0; i--)
            tick_q.push_back(t_tick'(OPENING_TICKS[3*i +: 3]));

        for (blk = 0; blk < 6; blk++) begin
            settle();
            case (blk)
                0: set_block(3, 1023, 0, 65535, 232, 0);
                1: set_block(2, 5, 100, 250, 65535, 65535);
                2: set_block($urandom_range(6, 1), $urandom_range(40, 2),
                             $urandom_range(240), $urandom_range(320, 200),
                             $urandom_range(320, 233), $urandom_range(40, 1));
                3: set_block(RST_TRIG_TICKS, RST_TIMEOUT_MS, RST_MIN_VALID,
                             RST_MAX_VALID, RST_RADAR_FAR, RST_BEEP_MS);
                4: set_block($urandom_range(6, 1), $urandom_range(40, 2), 65535, 0,
                             $urandom_range(320, 233), $urandom_range(40, 1));
                default: set_block(255, 1023, 0, 65535, 300, $urandom_range(40, 1));
            endcase
            if (blk < 2) begin
                send_idle_pct = 8;
                recv_idle_pct = 53;
            end else if (blk < 4) begin
                send_idle_pct = 53;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (blk == 0) begin
                // A poll, then a run of strobes that the long timeout absorbs, so the
                // second poll still finds the ranger busy.
                add_tick(1'b0, 1'b0, 1'b1);
                repeat (3) add_tick(1'b0, 1'b0, 1'b0);
                repeat (40) add_tick(1'b0, 1'b1, 1'b0);
                add_tick(1'b0, 1'b0, 1'b1);
            end else if (blk == 5) begin
                // From any state these ticks end up waiting for an echo: the first
                // quiet stretch ends a trigger, the pulse finishes a wait, and the two polls
                // collect any result and start a trigger that a later quiet stretch ends.
                repeat (gen_trig + 1) add_tick(1'b0, 1'b0, 1'b0);
                add_tick(1'b1, 1'b0, 1'b0);
                add_tick(1'b0, 1'b0, 1'b0);
                add_tick(1'b0, 1'b0, 1'b1);
                repeat (gen_trig + 1) add_tick(1'b0, 1'b0, 1'b0);
                add_tick(1'b0, 1'b0, 1'b1);
                repeat (gen_trig + 1) add_tick(1'b0, 1'b0, 1'b0);
            end

            start = queued_ticks;
            while (queued_ticks - start < BLOCK_TICKS) begin
                if (coin(20)) begin
                    repeat ($urandom_range(6, 1)) add_tick(coin(50), coin(50), coin(15));
                end else begin
                    queue_ranging();
                end
            end
        end

        settle();
        if (mismatches == 0 && due_readings.size() == 0)
            $display("ultrasonic_ranger_proximity_beeper test passed");
        else
            $display("ultrasonic_ranger_proximity_beeper test failed");
        $finish;
    end

endmodule
